// ----- hw/rtl/ctf_pkg.sv -----
package ctf_pkg;

   // Field widths.
   localparam int ACCEL_W  = 18;
   localparam int GYRO_W   = 24;
   localparam int TILT_W   = 24;
   localparam int ANGLE_W  = 32;
   localparam int CSR_W    = 32;
   localparam int COEF_W   = 16;
   localparam int CSR_IDX_W = 2;

   // CORDIC datapath: vector components and Q28 angle.
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORDIC_MAX_STEPS = 24;
   localparam int VEC_W   = 34;
   localparam int PHASE_W = 32;

   // Shared serial multiplier: signed multiplicand, unsigned multiplier.
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 21;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int Q_SHIFT = 15;

   localparam logic signed [PHASE_W-1:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic signed [MUL_A_W-1:0] OFFSET_Q28  = 33'sd842887332;
   localparam logic [MUL_B_W-1:0] DEG_PER_RAD_Q15    = 21'd1877468;
   localparam logic [TILT_W-1:0]  TILT_MAX           = 24'hFFFFFF;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GW     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AW     = 2'd3;

   localparam logic signed [ANGLE_W-1:0] TARGET_RST = '0;
   localparam logic [COEF_W-1:0] DT_RST = 16'd32;
   localparam logic [COEF_W-1:0] GW_RST = 16'd32735;
   localparam logic [COEF_W-1:0] AW_RST = 16'd32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_DEG,
      ST_DELTA,
      ST_GAIN,
      ST_ACCEL,
      ST_WRITE
   } seq_state_type;

   // Arctangent of 2^-i in Q28 radians.
   function automatic logic signed [PHASE_W-1:0] atan_q28(input logic [4:0] idx);
      logic signed [PHASE_W-1:0] val;
      case (idx)
         5'd0:  val = 32'sd210828714;
         5'd1:  val = 32'sd124459457;
         5'd2:  val = 32'sd65760959;
         5'd3:  val = 32'sd33381290;
         5'd4:  val = 32'sd16755422;
         5'd5:  val = 32'sd8385879;
         5'd6:  val = 32'sd4193963;
         5'd7:  val = 32'sd2097109;
         5'd8:  val = 32'sd1048571;
         5'd9:  val = 32'sd524287;
         5'd10: val = 32'sd262144;
         5'd11: val = 32'sd131072;
         5'd12: val = 32'sd65536;
         5'd13: val = 32'sd32768;
         5'd14: val = 32'sd16384;
         5'd15: val = 32'sd8192;
         5'd16: val = 32'sd4096;
         5'd17: val = 32'sd2048;
         5'd18: val = 32'sd1024;
         5'd19: val = 32'sd512;
         5'd20: val = 32'sd256;
         5'd21: val = 32'sd128;
         5'd22: val = 32'sd64;
         5'd23: val = 32'sd32;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- hw/rtl/ctf_req_if.sv -----
interface ctf_req_if;
   logic valid;
   logic ready;
   logic signed [ctf_pkg::ACCEL_W-1:0] accel_y;
   logic signed [ctf_pkg::ACCEL_W-1:0] accel_z;
   logic signed [ctf_pkg::GYRO_W-1:0]  gyro_z;

   modport source (output valid, accel_y, accel_z, gyro_z, input ready);
   modport sink   (input valid, accel_y, accel_z, gyro_z, output ready);
endinterface

// ----- hw/rtl/ctf_rsp_if.sv -----
interface ctf_rsp_if;
   logic valid;
   logic ready;
   logic [ctf_pkg::TILT_W-1:0]         accel_tilt;
   logic signed [ctf_pkg::ANGLE_W-1:0] fused_angle;
   logic signed [ctf_pkg::ANGLE_W-1:0] angle_error;

   modport source (output valid, accel_tilt, fused_angle, angle_error, input ready);
   modport sink   (input valid, accel_tilt, fused_angle, angle_error, output ready);
endinterface

// ----- hw/rtl/ctf_cordic.sv -----
module ctf_cordic #(
   parameter int CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [ctf_pkg::VEC_W-1:0]     vec_x,
   input  logic signed [ctf_pkg::VEC_W-1:0]     vec_y,
   output logic                                 done,
   output logic signed [ctf_pkg::PHASE_W-1:0]   phase
);
   import ctf_pkg::*;

   localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

   logic signed [VEC_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [PHASE_W-1:0] z_ff, z_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      zero_ff, zero_in;
   logic                      done_ff, done_in;
   logic [4:0]                step_idx;

   assign step_idx = 5'(cnt_ff);

   // One micro-rotation per cycle; the quarter turn is applied at start.
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
         zero_in = (vec_x == '0) && (vec_y == '0);
         if (vec_x < 0) begin
            if (vec_y >= 0) begin
               x_in = vec_y;
               y_in = -vec_x;
               z_in = HALF_PI_Q28;
            end else begin
               x_in = -vec_y;
               y_in = vec_x;
               z_in = -HALF_PI_Q28;
            end
         end else begin
            x_in = vec_x;
            y_in = vec_y;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(CORDIC_STEPS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            if (y_ff >= 0) begin
               x_in = x_ff + (y_ff >>> cnt_ff);
               y_in = y_ff - (x_ff >>> cnt_ff);
               z_in = z_ff + atan_q28(step_idx);
            end else begin
               x_in = x_ff - (y_ff >>> cnt_ff);
               y_in = y_ff + (x_ff >>> cnt_ff);
               z_in = z_ff - atan_q28(step_idx);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
   end

   assign done  = done_ff;
   assign phase = zero_ff ? '0 : z_ff;

endmodule

// ----- hw/rtl/ctf_serial_mult.sv -----
module ctf_serial_mult (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [ctf_pkg::MUL_A_W-1:0]  mcand,
   input  logic [ctf_pkg::MUL_B_W-1:0]         mplier,
   output logic                                done,
   output logic signed [ctf_pkg::PROD_W-1:0]   product
);
   import ctf_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W + 1);

   logic signed [PROD_W-1:0] acc_ff, acc_in, a_ff, a_in;
   logic [MUL_B_W-1:0]       b_ff, b_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   // Shift-add: one multiplier bit per cycle, LSB first.
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = PROD_W'(mcand);
         b_in    = mplier;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = a_ff <<< 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- hw/rtl/complementary_tilt_filter.sv -----
// Channel  | Dir | Beat contents
// req_chan | in  | accel_y, accel_z, gyro_z
// rsp_chan | out | accel_tilt, fused_angle, angle_error
// csr_*    | in  | write enable, register index, write data
//
// Each beat runs the CORDIC iterations followed by four products through one
// bit-serial multiplier. Reset is synchronous and active high; it restores the
// register defaults and zeroes the fused angle. A new beat is accepted while a
// finished result waits in the output register; the sequencer stalls only when a
// second result is ready.
module complementary_tilt_filter #(
   parameter int CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   ctf_req_if.sink                           req_chan,
   ctf_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_en,
   input  logic [ctf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ctf_pkg::CSR_W-1:0]         csr_write_data
);
   import ctf_pkg::*;

   seq_state_type state_ff, state_in;

   logic signed [ANGLE_W-1:0] target_ff;
   logic [COEF_W-1:0]         dt_ff, gw_ff, aw_ff;
   logic signed [ANGLE_W-1:0] fused_ff, fused_in;
   logic signed [GYRO_W-1:0]  gyro_ff;
   logic [TILT_W-1:0]         deg_ff, deg_in;
   logic signed [ANGLE_W-1:0] gain_ff, gain_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [TILT_W-1:0]         out_tilt_ff, out_tilt_in;
   logic signed [ANGLE_W-1:0] out_fused_ff, out_fused_in;
   logic signed [ANGLE_W-1:0] out_err_ff, out_err_in;

   logic                      accept;
   logic signed [VEC_W-1:0]   ay_ext, az_ext, cordic_x, cordic_y;
   logic                      cordic_done;
   logic signed [PHASE_W-1:0] cordic_phase;
   logic signed [MUL_A_W-1:0] phase_sum, phase_q15;
   logic                      mul_start, mul_done;
   logic signed [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [PROD_W-Q_SHIFT-1:0] prod_q;
   logic signed [ANGLE_W-1:0] prod_lo;
   logic signed [ANGLE_W-1:0] diff_angle;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RST;
         dt_ff     <= DT_RST;
         gw_ff     <= GW_RST;
         aw_ff     <= AW_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_TARGET: target_ff <= csr_write_data;
            CSR_DT:     dt_ff     <= csr_write_data[COEF_W-1:0];
            CSR_GW:     gw_ff     <= csr_write_data[COEF_W-1:0];
            CSR_AW:     aw_ff     <= csr_write_data[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // CORDIC operands: y = -(ay >> 2) << 14, x = (az >> 2) << 14.
   assign ay_ext   = VEC_W'(req_chan.accel_y);
   assign az_ext   = VEC_W'(req_chan.accel_z);
   assign cordic_y = (-(ay_ext >>> 2)) <<< 14;
   assign cordic_x = (az_ext >>> 2) <<< 14;

   ctf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .vec_x (cordic_x),
      .vec_y (cordic_y),
      .done  (cordic_done),
      .phase (cordic_phase)
   );

   // Offset by 3.14 rad, then Q28 to Q15 truncating toward zero.
   assign phase_sum = MUL_A_W'(cordic_phase) + OFFSET_Q28;
   assign phase_q15 = (phase_sum >= 0) ? (phase_sum >>> 13) : -((-phase_sum) >>> 13);

   ctf_serial_mult u_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   assign prod_q  = mul_p[PROD_W-1:Q_SHIFT];
   assign prod_lo = prod_q[ANGLE_W-1:0];

   // Propagated angle wraps at the angle width before it is weighted.
   assign diff_angle = fused_ff - prod_lo;

   // Sequencer: CORDIC, then four products, then the output register.
   always_comb begin
      state_in     = state_ff;
      mul_start    = 1'b0;
      mul_a        = phase_q15;
      mul_b        = DEG_PER_RAD_Q15;
      deg_in       = deg_ff;
      gain_in      = gain_ff;
      fused_in     = fused_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_tilt_in  = out_tilt_ff;
      out_fused_in = out_fused_ff;
      out_err_in   = out_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               mul_start = 1'b1;
               state_in  = ST_DEG;
            end
         end
         ST_DEG: begin
            mul_a = MUL_A_W'(gyro_ff);
            mul_b = MUL_B_W'(dt_ff);
            if (mul_done) begin
               if (prod_q[PROD_W-Q_SHIFT-1]) begin
                  deg_in = '0;
               end else if (|prod_q[PROD_W-Q_SHIFT-2:TILT_W]) begin
                  deg_in = TILT_MAX;
               end else begin
                  deg_in = prod_q[TILT_W-1:0];
               end
               mul_start = 1'b1;
               state_in  = ST_DELTA;
            end
         end
         ST_DELTA: begin
            mul_a = MUL_A_W'(diff_angle);
            mul_b = MUL_B_W'(gw_ff);
            if (mul_done) begin
               mul_start = 1'b1;
               state_in  = ST_GAIN;
            end
         end
         ST_GAIN: begin
            mul_a = MUL_A_W'({1'b0, deg_ff});
            mul_b = MUL_B_W'(aw_ff);
            if (mul_done) begin
               gain_in   = prod_lo;
               mul_start = 1'b1;
               state_in  = ST_ACCEL;
            end
         end
         ST_ACCEL: begin
            if (mul_done) begin
               fused_in = gain_ff + prod_lo;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               out_tilt_in  = deg_ff;
               out_fused_in = fused_ff;
               out_err_in   = target_ff - fused_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fused_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fused_ff     <= fused_in;
      end
      if (accept) begin
         gyro_ff <= req_chan.gyro_z;
      end
      deg_ff       <= deg_in;
      gain_ff      <= gain_in;
      out_tilt_ff  <= out_tilt_in;
      out_fused_ff <= out_fused_in;
      out_err_ff   <= out_err_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.accel_tilt  = out_tilt_ff;
   assign rsp_chan.fused_angle = out_fused_ff;
   assign rsp_chan.angle_error = out_err_ff;

endmodule

// ----- test/complementary_tilt_filter_tb.sv -----
module complementary_tilt_filter_tb;
   import ctf_pkg::*;

   typedef struct {
      logic signed [ACCEL_W-1:0] accel_y;
      logic signed [ACCEL_W-1:0] accel_z;
      logic signed [GYRO_W-1:0]  gyro_z;
   } imu_sample_type;

   typedef struct {
      logic [TILT_W-1:0]         accel_tilt;
      logic signed [ANGLE_W-1:0] fused_angle;
      logic signed [ANGLE_W-1:0] angle_error;
   } tilt_result_type;

   localparam int STEPS        = CORDIC_STEPS_DEF;
   localparam int IDLE_LIMIT   = 5000;
   localparam int SETTLE_WAIT  = 150;
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_ITEMS  = 178;
   localparam int LONG_HOLD    = 700;
   localparam int HOLD_AT_BEAT = 300;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_write_data;

   ctf_req_if req_if();
   ctf_rsp_if rsp_if();

   complementary_tilt_filter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Arctangent of 2^-i in Q28 radians.
   longint atan_steps [24] = '{
      210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
      4193963, 2097109, 1048571, 524287, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048,
      1024, 512, 256, 128, 64, 32
   };

   // Predictor copies of the registers and the filter state.
   longint target_q15;
   longint dt_q15;
   longint gyro_gain;
   longint accel_gain;
   longint fused_state;

   imu_sample_type  sample_queue[$];
   tilt_result_type expected_results[$];
   int error_count = 0;
   int rsp_beats = 0;
   int idle_cycles = 0;

   function automatic longint wrap_angle(longint v);
      return longint'(int'(v));
   endfunction

   // Vectoring CORDIC in Q28 radians with the quarter-turn pre-rotation.
   function automatic longint vector_angle(longint y, longint x);
      longint z;
      longint t;
      longint dx;
      longint dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = 421657428;
         end else begin
            x = -y;
            y = t;
            z = -421657428;
         end
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx;
            y -= dy;
            z += atan_steps[i];
         end else begin
            x -= dx;
            y += dy;
            z -= atan_steps[i];
         end
      end
      return z;
   endfunction

   // Works out the beat the filter must return and advances the fused angle.
   function automatic tilt_result_type fuse_sample(imu_sample_type s);
      tilt_result_type r;
      longint y;
      longint x;
      longint sum;
      longint trunc;
      longint deg;
      longint delta;
      longint diff;
      longint fused;
      longint err;
      y = -(longint'(s.accel_y) >>> 2) * 16384;
      x = (longint'(s.accel_z) >>> 2) * 16384;
      sum = vector_angle(y, x) + 842887332;
      trunc = (sum >= 0) ? (sum >>> 13) : -((-sum) >>> 13);
      deg = (trunc * 1877468) >>> 15;
      if (deg < 0) deg = 0;
      if (deg > 64'hFFFFFF) deg = 64'hFFFFFF;
      delta = (longint'(s.gyro_z) * dt_q15) >>> 15;
      diff = wrap_angle(fused_state - delta);
      fused = wrap_angle(((diff * gyro_gain) >>> 15) + ((deg * accel_gain) >>> 15));
      fused_state = fused;
      err = wrap_angle(target_q15 - fused);
      r.accel_tilt = deg[TILT_W-1:0];
      r.fused_angle = fused[ANGLE_W-1:0];
      r.angle_error = err[ANGLE_W-1:0];
      return r;
   endfunction

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Sender: bursts of beats separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.accel_y <= '0;
         req_if.accel_z <= '0;
         req_if.gyro_z <= '0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            imu_sample_type s;
            s = sample_queue.pop_front();
            req_if.accel_y <= s.accel_y;
            req_if.accel_z <= s.accel_z;
            req_if.gyro_z <= s.gyro_z;
            req_if.valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(20);
               gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(150);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Input monitor: every accepted beat gets its prediction.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         imu_sample_type s;
         s.accel_y = req_if.accel_y;
         s.accel_z = req_if.accel_z;
         s.gyro_z = req_if.gyro_z;
         expected_results.push_back(fuse_sample(s));
      end
   end

   // Receiver: stall pattern rotates through four modes, plus one long hold-off.
   int rx_cycle = 0;
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      rx_cycle++;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (!hold_done && rsp_beats == HOLD_AT_BEAT) begin
         hold_done = 1;
         hold_left = LONG_HOLD;
         rsp_if.ready <= 1'b0;
      end else begin
         case ((rx_cycle / 512) % 4)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(1) == 0);
            2: rsp_if.ready <= ((rx_cycle % 97) > 60);
            default: rsp_if.ready <= ($urandom_range(7) == 0);
         endcase
      end
   end

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         rsp_beats++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result beat tilt=%0d fused=%0d error=%0d", $time,
                     rsp_if.accel_tilt, rsp_if.fused_angle, rsp_if.angle_error);
            error_count++;
         end else begin
            tilt_result_type e;
            e = expected_results.pop_front();
            if (rsp_if.accel_tilt !== e.accel_tilt) begin
               $display("%0t: accel_tilt expected %0d actual %0d", $time,
                        e.accel_tilt, rsp_if.accel_tilt);
               error_count++;
            end
            if (rsp_if.fused_angle !== e.fused_angle) begin
               $display("%0t: fused_angle expected %0d actual %0d", $time,
                        e.fused_angle, rsp_if.fused_angle);
               error_count++;
            end
            if (rsp_if.angle_error !== e.angle_error) begin
               $display("%0t: angle_error expected %0d actual %0d", $time,
                        e.angle_error, rsp_if.angle_error);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no beat on either channel.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_registers(longint tgt, longint dt, longint gw, longint aw);
      longint vals [4];
      vals = '{tgt, dt, gw, aw};
      for (int i = 0; i < 4; i++) begin
         @(posedge clock);
         csr_write_en <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_write_data <= vals[i][CSR_W-1:0];
      end
      @(posedge clock);
      csr_write_en <= 1'b0;
      target_q15 = wrap_angle(tgt);
      dt_q15 = dt & 16'hFFFF;
      gyro_gain = gw & 16'hFFFF;
      accel_gain = aw & 16'hFFFF;
   endtask

   task automatic add_sample(int ay, int az, int gz);
      imu_sample_type s;
      s.accel_y = ACCEL_W'(ay);
      s.accel_z = ACCEL_W'(az);
      s.gyro_z = GYRO_W'(gz);
      sample_queue.push_back(s);
   endtask

   // Mostly plausible sensor readings, with some full-range noise.
   task automatic add_random_sample();
      imu_sample_type s;
      int mag;
      if ($urandom_range(4) == 0) begin
         s.accel_y = ACCEL_W'($urandom);
         s.accel_z = ACCEL_W'($urandom);
         s.gyro_z = GYRO_W'($urandom);
      end else begin
         mag = $urandom_range(131071, 16);
         s.accel_y = ACCEL_W'($signed($urandom_range(2 * mag)) - mag);
         s.accel_z = ACCEL_W'($signed($urandom_range(2 * mag)) - mag);
         s.gyro_z = GYRO_W'($signed($urandom_range(2000000)) - 1000000);
      end
      sample_queue.push_back(s);
   endtask

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.accel_y = '0;
      req_if.accel_z = '0;
      req_if.gyro_z = '0;
      rsp_if.ready = 1'b0;
      target_q15 = 0;
      dt_q15 = 32;
      gyro_gain = 32735;
      accel_gain = 32;
      fused_state = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: write_registers(0, 32, 32735, 32);
            1: write_registers(64'h7FFFFFFF, 65535, 32768, 0);
            2: write_registers(-64'sd2147483648, 0, 0, 32768);
            3: write_registers(longint'($signed($urandom)), $urandom_range(65535),
                               65535, 65535);
            default: write_registers(longint'($signed($urandom)), $urandom_range(2000),
                                     $urandom_range(32768), $urandom_range(32768));
         endcase
         if (ph == 0) begin
            // Field extremes, zero vector, both halves of the left plane,
            // tilt that saturates at zero, and the gyro limits.
            add_sample(0, 0, 0);
            add_sample(3, -3, 0);
            add_sample(-131072, -131072, -8388608);
            add_sample(131071, 131071, 8388607);
            add_sample(-131072, 131071, 0);
            add_sample(131071, -131072, 0);
            add_sample(0, 131071, 1);
            add_sample(0, -131072, -1);
            add_sample(4, -131072, 0);
            add_sample(-4, -131072, 0);
            add_sample(8, -131072, 100);
            add_sample(131071, 0, 0);
            add_sample(-131072, 0, 0);
            add_sample(16384, -16384, 32768);
            add_sample(-16384, -16384, -32768);
            add_sample(-16384, 16384, 8388607);
            add_sample(16384, 16384, -8388608);
            add_sample(1, 32767, 0);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) add_random_sample();
         // The last beat must be accepted and its result returned before
         // the registers change again.
         wait (sample_queue.size() == 0 && !req_if.valid && expected_results.size() == 0);
         repeat (SETTLE_WAIT) @(posedge clock);
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/ctf_pkg.sv
hw/rtl/ctf_req_if.sv
hw/rtl/ctf_rsp_if.sv
hw/rtl/ctf_cordic.sv
hw/rtl/ctf_serial_mult.sv
hw/rtl/complementary_tilt_filter.sv
test/complementary_tilt_filter_tb.sv
